// ----- sv/mts_pkg.sv -----
// Shared constants, types and helpers for the markup tag scanner.
package mts_pkg;

    // Offsets count up to and saturate at the document limit.
    localparam int unsigned MAX_DOC_BYTES = 65536;
    localparam int unsigned OFS_W         = $clog2(MAX_DOC_BYTES + 1);

    typedef logic [OFS_W-1:0] ofs_t;

    localparam ofs_t OFS_LIMIT = OFS_W'(MAX_DOC_BYTES);

    // Tag name classes.
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_SVG   = 2'd1;
    localparam logic [1:0] KIND_PATH  = 2'd2;

    // Characters the scanner reacts to.
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_FF    = 8'h0C;

    // One reported open tag.
    typedef struct packed {
        logic       hit;
        logic [1:0] tag_kind;
        ofs_t       name_begin;
        ofs_t       name_finish;
        ofs_t       attrs_finish;
        logic       unterminated;
    } mts_result_t;

    // Letters of "svg" by position.
    function automatic logic [7:0] svg_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h73;
            2'd1:    c = 8'h76;
            2'd2:    c = 8'h67;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Letters of "path" by position.
    function automatic logic [7:0] path_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h70;
            2'd1:    c = 8'h61;
            2'd2:    c = 8'h74;
            default: c = 8'h68;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/mts_scan.sv -----
// Byte-level scanner state machine: tracks the document position and finds open tags.
module mts_scan
    import mts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  doc_byte,
    input  logic        doc_end,
    output mts_result_t res
);

    localparam logic [3:0] PH_SEEK    = 4'd0;
    localparam logic [3:0] PH_LT      = 4'd1;
    localparam logic [3:0] PH_BANG0   = 4'd2;
    localparam logic [3:0] PH_BANG1   = 4'd3;
    localparam logic [3:0] PH_COMMENT = 4'd4;
    localparam logic [3:0] PH_SKIP    = 4'd5;
    localparam logic [3:0] PH_NAME    = 4'd6;
    localparam logic [3:0] PH_ATTR    = 4'd7;
    localparam logic [3:0] PH_QUOTE   = 4'd8;

    logic [3:0] phase_reg, phase_next;
    ofs_t       offset_reg, offset_next;
    ofs_t       begin_reg, begin_next;
    ofs_t       finish_reg, finish_next;
    logic       single_reg, single_next;
    logic [1:0] dash_reg, dash_next;
    logic [2:0] nlen_reg, nlen_next;
    logic [1:0] match_reg, match_next;

    ofs_t       len;
    logic       delim;
    logic       do_name;
    logic       hit;
    ofs_t       attrs_end;
    logic       unterm;
    logic [1:0] kind;

    assign len = (offset_reg < OFS_LIMIT) ? offset_reg + ofs_t'(1) : OFS_LIMIT;

    assign delim = (doc_byte == CH_SPACE) || (doc_byte == CH_TAB) || (doc_byte == CH_LF) ||
                   (doc_byte == CH_CR) || (doc_byte == CH_FF) || (doc_byte == CH_GT) ||
                   (doc_byte == CH_SLASH);

    always_comb begin
        phase_next  = phase_reg;
        begin_next  = begin_reg;
        finish_next = finish_reg;
        single_next = single_reg;
        dash_next   = dash_reg;
        nlen_next   = nlen_reg;
        match_next  = match_reg;
        do_name     = 1'b0;
        hit         = 1'b0;
        attrs_end   = offset_reg;
        unterm      = 1'b0;

        case (phase_reg)
            PH_SEEK: begin
                if (doc_byte == CH_LT) begin
                    phase_next = PH_LT;
                    nlen_next  = 3'd0;
                    match_next = 2'b11;
                end
            end
            PH_LT: begin
                if (doc_byte == CH_BANG) begin
                    phase_next = PH_BANG0;
                end else if (doc_byte == CH_QMARK || doc_byte == CH_SLASH) begin
                    phase_next = PH_SKIP;
                end else begin
                    begin_next = offset_reg;
                    phase_next = PH_NAME;
                    do_name    = 1'b1;
                end
            end
            PH_BANG0, PH_BANG1: begin
                if (doc_byte == CH_DASH) begin
                    if (phase_reg == PH_BANG1) begin
                        phase_next = PH_COMMENT;
                        dash_next  = 2'd0;
                    end else begin
                        phase_next = PH_BANG1;
                    end
                end else begin
                    phase_next = (doc_byte == CH_GT) ? PH_SEEK : PH_SKIP;
                end
            end
            PH_COMMENT: begin
                if (doc_byte == CH_DASH) begin
                    if (dash_reg < 2'd2) begin
                        dash_next = dash_reg + 2'd1;
                    end
                end else begin
                    if (doc_byte == CH_GT && dash_reg == 2'd2) begin
                        phase_next = PH_SEEK;
                    end
                    dash_next = 2'd0;
                end
            end
            PH_SKIP: begin
                if (doc_byte == CH_GT) begin
                    phase_next = PH_SEEK;
                end
            end
            PH_NAME: begin
                do_name = 1'b1;
            end
            PH_ATTR: begin
                if (doc_byte == CH_GT) begin
                    phase_next = PH_SEEK;
                    hit        = 1'b1;
                end else if (doc_byte == CH_DQUOT || doc_byte == CH_SQUOT) begin
                    single_next = (doc_byte == CH_SQUOT);
                    phase_next  = PH_QUOTE;
                end
            end
            PH_QUOTE: begin
                if (doc_byte == (single_reg ? CH_SQUOT : CH_DQUOT)) begin
                    phase_next = PH_ATTR;
                end
            end
            default: begin
                phase_next = PH_SEEK;
            end
        endcase

        // A name byte either extends the name and narrows the match, or ends the
        // name and is then treated as the first attribute byte.
        if (do_name) begin
            if (delim) begin
                finish_next = offset_reg;
                phase_next  = PH_ATTR;
                if (doc_byte == CH_GT) begin
                    phase_next = PH_SEEK;
                    hit        = 1'b1;
                end
            end else begin
                if (nlen_reg >= 3'd3 || doc_byte != svg_char(nlen_reg[1:0])) begin
                    match_next[0] = 1'b0;
                end
                if (nlen_reg >= 3'd4 || doc_byte != path_char(nlen_reg[1:0])) begin
                    match_next[1] = 1'b0;
                end
                if (nlen_reg < 3'd5) begin
                    nlen_next = nlen_reg + 3'd1;
                end
            end
        end

        // The final byte closes any tag that is still open.
        if (doc_end && !hit) begin
            if (phase_next == PH_LT) begin
                begin_next  = len;
                finish_next = len;
                hit         = 1'b1;
            end else if (phase_next == PH_NAME) begin
                finish_next = len;
                hit         = 1'b1;
            end else if (phase_next == PH_ATTR || phase_next == PH_QUOTE) begin
                hit = 1'b1;
            end
            if (hit) begin
                attrs_end = len;
                unterm    = 1'b1;
            end
        end

        if (match_next[0] && nlen_next == 3'd3) begin
            kind = KIND_SVG;
        end else if (match_next[1] && nlen_next == 3'd4) begin
            kind = KIND_PATH;
        end else begin
            kind = KIND_OTHER;
        end

        offset_next = len;

        if (doc_end) begin
            phase_next  = PH_SEEK;
            offset_next = '0;
            single_next = 1'b0;
            dash_next   = 2'd0;
            nlen_next   = 3'd0;
            match_next  = 2'b11;
        end
    end

    assign res.hit          = hit;
    assign res.tag_kind     = kind;
    assign res.name_begin   = begin_next;
    assign res.name_finish  = finish_next;
    assign res.attrs_finish = attrs_end;
    assign res.unterminated = unterm;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SEEK;
            offset_reg <= '0;
            begin_reg  <= '0;
            finish_reg <= '0;
            single_reg <= 1'b0;
            dash_reg   <= 2'd0;
            nlen_reg   <= 3'd0;
            match_reg  <= 2'b11;
        end else if (step) begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            begin_reg  <= doc_end ? ofs_t'(0) : begin_next;
            finish_reg <= doc_end ? ofs_t'(0) : finish_next;
            single_reg <= single_next;
            dash_reg   <= dash_next;
            nlen_reg   <= nlen_next;
            match_reg  <= match_next;
        end
    end

endmodule

// ----- sv/markup_tag_scanner.sv -----
// Top level of the markup tag scanner: stream ports, scanner and result register.
//
// The scanner takes a markup document one byte per request on the slave side,
// with tlast on the final byte, and reports every open tag as one request on
// the master side: the byte offsets of the name start, the name end (where the
// attributes start) and the closing '>', plus the name class (other, svg or
// path, exact and case sensitive). Text, comments, declarations, processing
// instructions and close tags produce nothing. A '>' inside a quoted attribute
// value does not close a tag. If the document ends inside an open tag, one
// result is still reported, flagged as unterminated, with every open span
// ending at the document length. After the final byte the scanner starts over
// at offset zero. Offsets saturate at the document limit in the package.
// The scanner state is updated in the cycle a byte is accepted, and the result
// is held in a single output register, so a byte is accepted in each cycle in
// which that register is empty or being drained. A result appears on the
// master side in the cycle after the byte that closed the tag is accepted.
// With an output that is never stalled the sustained rate is one byte per
// clock cycle.
module markup_tag_scanner
    import mts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // doc_byte
    input  logic        s_tlast,   // doc_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // name_begin, name_finish, attrs_finish, zero fill
    output logic [2:0]  m_tuser    // tag_kind, unterminated
);

    localparam int unsigned DATA_BITS = 3 * OFS_W;

    mts_result_t res;
    mts_result_t out_reg;
    logic        m_valid_reg, m_valid_next;
    logic        accept;

    // The output register may be refilled in the same cycle it is emptied.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    mts_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (accept),
        .doc_byte (s_tdata),
        .doc_end  (s_tlast),
        .res      (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = res.hit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload needs no reset; it is only loaded together with a valid result.
    always_ff @(posedge aclk) begin
        if (accept && res.hit) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(56 - DATA_BITS){1'b0}},
                       out_reg.attrs_finish, out_reg.name_finish, out_reg.name_begin};
    assign m_tuser  = {out_reg.unterminated, out_reg.tag_kind};

endmodule
